>>> sv/cosine_reciprocating_trajectory_assert.svh
// Assertion macros for the raised-cosine trajectory generator
`ifndef COSINE_RECIPROCATING_TRAJECTORY_ASSERT_SVH
`define COSINE_RECIPROCATING_TRAJECTORY_ASSERT_SVH

`ifndef SYNTHESIS
`define CRT_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("crt assertion failed");
`define CRT_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("crt assertion failed");
`else
`define CRT_ASSERT_IMPL(name, pre, post)
`define CRT_ASSERT_NEXT(name, pre, post)
`endif

`endif

>>> sv/crt_pkg.sv
// Shared types, constants and cosine table function for the trajectory generator
package crt_pkg;

  localparam int COS_TABLE_DEPTH = 256;
  localparam int POSITION_BITS = 32;
  localparam int COS_ADDR_BITS = $clog2(COS_TABLE_DEPTH);
  localparam int COS_IDX_BITS = COS_ADDR_BITS + 1;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    REG_AMPLITUDE = 2'd0,
    REG_PERIOD    = 2'd1,
    REG_CYCLES    = 2'd2,
    REG_STEP      = 2'd3
  } crt_reg_t;

  typedef enum logic [1:0] {
    SEG_IDLE   = 2'd0,
    SEG_RISE   = 2'd1,
    SEG_SWING  = 2'd2,
    SEG_RETURN = 2'd3
  } crt_seg_t;

  typedef struct packed {
    logic signed [31:0] amplitude;
    logic [31:0]        phase_step;
    logic [23:0]        total;
    logic [14:0]        half;
    logic [23:0]        tail_start;
  } crt_cfg_t;

  typedef struct packed {
    logic        tgt_valid;
    crt_seg_t    seg;
    logic [23:0] remaining;
    logic [31:0] phase;
    logic [31:0] base;
  } crt_s1_t;

  typedef struct packed {
    logic        tgt_valid;
    crt_seg_t    seg;
    logic [23:0] remaining;
    logic [30:0] w;
    logic [31:0] base;
  } crt_s2_t;

  typedef struct packed {
    logic               tgt_valid;
    crt_seg_t           seg;
    logic [23:0]        remaining;
    logic signed [63:0] prod;
    logic [31:0]        base;
  } crt_s3_t;

  function automatic logic [30:0] cos_entry(input int unsigned idx);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic signed [63:0] c;
    x = (64'(idx) * HALF_PI_Q30 + 64'(COS_TABLE_DEPTH / 2)) / 64'(COS_TABLE_DEPTH);
    x2 = (x * x) >> 30;
    t = Q30_ONE;
    t = Q30_ONE - ((x2 * t) >> 30) / 64'd182;
    t = Q30_ONE - ((x2 * t) >> 30) / 64'd132;
    t = Q30_ONE - ((x2 * t) >> 30) / 64'd90;
    t = Q30_ONE - ((x2 * t) >> 30) / 64'd56;
    t = Q30_ONE - ((x2 * t) >> 30) / 64'd30;
    t = Q30_ONE - ((x2 * t) >> 30) / 64'd12;
    c = $signed(Q30_ONE) - $signed(((x2 * t) >> 30) >> 1);
    if (c < 64'sd0) begin
      c = 64'sd0;
    end
    if (c > $signed(Q30_ONE)) begin
      c = $signed(Q30_ONE);
    end
    return c[30:0];
  endfunction

endpackage

>>> sv/crt_cfg.sv
// APB register file with derived move length and segment bounds
module crt_cfg import crt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output crt_cfg_t    cfg
);

  logic signed [31:0] amplitude;
  logic [15:0]        period_ticks;
  logic [7:0]         cycle_count;
  logic [31:0]        phase_step;
  logic [23:0]        total;
  logic [14:0]        half;
  logic [23:0]        tail_start;

  logic        wr;
  crt_reg_t    sel;
  logic [15:0] period_next;
  logic [7:0]  cycle_next;
  logic [23:0] total_next;
  logic [14:0] half_next;

  assign wr  = psel & penable & pwrite;
  assign sel = crt_reg_t'(paddr[3:2]);

  always_comb begin
    period_next = (wr && sel == REG_PERIOD) ? pwdata[15:0] : period_ticks;
    cycle_next  = (wr && sel == REG_CYCLES) ? pwdata[7:0] : cycle_count;
    total_next  = {8'd0, period_next} * {16'd0, cycle_next};
    half_next   = period_next[15:1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude    <= 32'sd0;
      period_ticks <= 16'd1000;
      cycle_count  <= 8'd2;
      phase_step   <= 32'd4294967;
      total        <= 24'd2000;
      half         <= 15'd500;
      tail_start   <= 24'd1500;
    end else begin
      if (wr && sel == REG_AMPLITUDE) begin
        amplitude <= $signed(pwdata);
      end
      if (wr && sel == REG_STEP) begin
        phase_step <= pwdata;
      end
      period_ticks <= period_next;
      cycle_count  <= cycle_next;
      total        <= total_next;
      half         <= half_next;
      tail_start   <= total_next - {9'd0, half_next};
    end
  end

  always_comb begin
    case (sel)
      REG_AMPLITUDE: prdata = amplitude;
      REG_PERIOD:    prdata = {16'd0, period_ticks};
      REG_CYCLES:    prdata = {24'd0, cycle_count};
      REG_STEP:      prdata = phase_step;
      default:       prdata = 32'd0;
    endcase
  end

  assign cfg.amplitude  = amplitude;
  assign cfg.phase_step = phase_step;
  assign cfg.total      = total;
  assign cfg.half       = half;
  assign cfg.tail_start = tail_start;

endmodule

>>> sv/crt_seq.sv
// Tick sequencer: move state, segment choice, base latch and phase accumulator
module crt_seq import crt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  crt_cfg_t    cfg,
  input  logic        acc,
  input  logic [31:0] actual_position,
  input  logic        restart,
  output crt_s1_t     s1_next
);

  logic [23:0] tick_count;
  logic        running;
  logic [31:0] phase_angle;
  logic [31:0] base_position;

  logic [23:0] n;
  logic        active;
  logic        in_range;
  crt_seg_t    seg;
  logic        first;
  logic [23:0] half_ext;
  logic [31:0] phase_next;
  logic [31:0] base_next;

  always_comb begin
    half_ext = {9'd0, cfg.half};
    n        = restart ? 24'd1 : tick_count + 24'd1;
    active   = restart | running;
    in_range = active && (n != 24'd0) && (n <= cfg.total);
    if (n <= half_ext) begin
      seg   = SEG_RISE;
      first = (n == 24'd1);
    end else if (n <= cfg.tail_start) begin
      seg   = SEG_SWING;
      first = (n == half_ext + 24'd1);
    end else begin
      seg   = SEG_RETURN;
      first = (n == cfg.tail_start + 24'd1);
    end
    phase_next = first ? cfg.phase_step : phase_angle + cfg.phase_step;
    base_next  = first ? actual_position : base_position;

    s1_next.tgt_valid = in_range;
    s1_next.seg       = in_range ? seg : SEG_IDLE;
    s1_next.remaining = in_range ? cfg.total - n : 24'd0;
    s1_next.phase     = phase_next;
    s1_next.base      = base_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= 24'd0;
      running       <= 1'b0;
      phase_angle   <= 32'd0;
      base_position <= 32'd0;
    end else if (acc && active) begin
      if (in_range) begin
        tick_count    <= n;
        running       <= (n < cfg.total);
        phase_angle   <= phase_next;
        base_position <= base_next;
      end else begin
        running <= 1'b0;
      end
    end
  end

endmodule

>>> sv/crt_cos.sv
// Quarter-wave cosine lookup producing the raised-cosine weight
module crt_cos import crt_pkg::*; (
  input  logic [31:0] phase,
  output logic [30:0] w
);

  logic [30:0] tab [0:COS_TABLE_DEPTH];

  for (genvar gi = 0; gi <= COS_TABLE_DEPTH; gi++) begin : g_tab
    assign tab[gi] = cos_entry(gi);
  end

  logic [1:0]              quad;
  logic [COS_ADDR_BITS-1:0] idx;
  logic [COS_IDX_BITS-1:0]  rev;
  logic [COS_IDX_BITS-1:0]  addr;
  logic                     neg;
  logic [31:0]              mag;
  logic [31:0]              diff;

  always_comb begin
    quad = phase[31:30];
    idx  = phase[29 -: COS_ADDR_BITS];
    rev  = COS_IDX_BITS'(COS_TABLE_DEPTH) - {1'b0, idx};
    addr = quad[0] ? rev : {1'b0, idx};
    neg  = quad[1] ^ quad[0];
    mag  = {1'b0, tab[addr]};
    diff = neg ? Q30_ONE[31:0] + mag : Q30_ONE[31:0] - mag;
    w    = diff[31:1];
  end

endmodule

>>> sv/cosine_reciprocating_trajectory.sv
// Raised-cosine reciprocating trajectory generator, top level
//
// One input word per servo tick on the s_ channel: s_tdata carries the measured
// joint position, s_tuser the restart flag. Every accepted word yields exactly
// one result word on the m_ channel: target position, valid flag, segment
// and ticks remaining. Idle or finished ticks give a word with the flag low.
// Amplitude, period, cycle count and phase step are written over the APB port;
// the user must write them only while no word is in flight, as the block does
// not enforce this; pready is always high. Pipeline: the accepting edge loads
// the sequencer register; the cosine lookup, multiplier and output registers
// follow. Throughput: one word per cycle while the receiver does not stall,
// set by the single 33x33 multiplier stage and the single-register state
// update in the sequencer. Reset (rst, synchronous) empties the pipeline,
// stops any move and restores the register defaults. When the receiver stalls,
// the pipeline keeps taking words until all four stages hold one; s_tready
// then drops until m_tready frees the output register.
module cosine_reciprocating_trajectory import crt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // [31:0] actual_position
  input  logic        s_tuser,  // [0] restart
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,  // [31:0] target_position, [55:32] remaining_ticks, [63:56] zero
  output logic [2:0]  m_tuser,  // [0] target_valid, [2:1] segment
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "cosine_reciprocating_trajectory_assert.svh"

  localparam int SUM_W = 66;
  localparam logic signed [SUM_W-1:0] POS_MAX = (66'sd1 <<< (POSITION_BITS - 1)) - 66'sd1;
  localparam logic signed [SUM_W-1:0] POS_MIN = -POS_MAX - 66'sd1;

  crt_cfg_t cfg;
  crt_s1_t  s1_next;
  crt_s1_t  s1;
  crt_s2_t  s2;
  crt_s3_t  s3;
  logic     v1;
  logic     v2;
  logic     v3;
  logic     acc;
  logic     out_ready;
  logic     r1;
  logic     r2;
  logic     r3;
  logic [30:0] w;

  logic signed [32:0]      a_eff;
  logic signed [64:0]      prod_full;
  logic signed [63:0]      scaled;
  logic signed [63:0]      q;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] pos_sat;

  assign pready = 1'b1;

  crt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  crt_seq u_seq (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .acc             (acc),
    .actual_position (s_tdata),
    .restart         (s_tuser),
    .s1_next         (s1_next)
  );

  crt_cos u_cos (
    .phase (s1.phase),
    .w     (w)
  );

  always_comb begin
    out_ready = ~m_tvalid | m_tready;
    r3        = ~v3 | out_ready;
    r2        = ~v2 | r3;
    r1        = ~v1 | r2;
    s_tready  = r1;
    acc       = s_tvalid & s_tready;
  end

  always_comb begin
    a_eff     = (s2.seg == SEG_RISE) ? 33'(cfg.amplitude) : -33'(cfg.amplitude);
    prod_full = a_eff * $signed({2'b00, s2.w});
    scaled    = (s3.seg == SEG_SWING) ? (s3.prod <<< 1) : s3.prod;
    q         = scaled >>> 30;
    sum       = SUM_W'(q) + SUM_W'($signed(s3.base));
    if (sum > POS_MAX) begin
      pos_sat = POS_MAX;
    end else if (sum < POS_MIN) begin
      pos_sat = POS_MIN;
    end else begin
      pos_sat = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (r1) begin
        v1 <= acc;
      end
      if (r2) begin
        v2 <= v1;
      end
      if (r3) begin
        v3 <= v2;
      end
      if (out_ready) begin
        m_tvalid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      s1 <= s1_next;
    end
    if (r2) begin
      s2.tgt_valid <= s1.tgt_valid;
      s2.seg       <= s1.seg;
      s2.remaining <= s1.remaining;
      s2.w         <= w;
      s2.base      <= s1.base;
    end
    if (r3) begin
      s3.tgt_valid <= s2.tgt_valid;
      s3.seg       <= s2.seg;
      s3.remaining <= s2.remaining;
      s3.prod      <= prod_full[63:0];
      s3.base      <= s2.base;
    end
    if (out_ready) begin
      m_tdata <= {8'd0, s3.remaining, s3.tgt_valid ? pos_sat[31:0] : 32'd0};
      m_tuser <= {s3.seg, s3.tgt_valid};
    end
  end

  `CRT_ASSERT_IMPL(a_stall_full, !s_tready, v1 && v2 && v3 && m_tvalid && !m_tready)
  `CRT_ASSERT_IMPL(a_flag_seg, m_tvalid, m_tuser[0] == (crt_seg_t'(m_tuser[2:1]) != SEG_IDLE))
  `CRT_ASSERT_IMPL(a_idle_zero, m_tvalid && !m_tuser[0], m_tdata == 64'd0)
  `CRT_ASSERT_NEXT(a_restart, acc && s_tuser && cfg.total != 24'd0,
                   v1 && s1.tgt_valid && s1.remaining == $past(cfg.total) - 24'd1)

endmodule
